@@ src/sqrc_pkg.sv @@
// Shared types and constants for the sequential run write cache.
// No dependencies; imported by every module of the block.
`default_nettype none
package sqrc_pkg;

   localparam int CACHE_BLOCKS_DEFAULT = 64;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_DISK_BLOCKS   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_BLOCK    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_IDLE_LIMIT    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CACHE_ENABLED = 2'd3;

   localparam logic [15:0] IDLE_LIMIT_RESET = 16'd1000;
   localparam logic [15:0] IDLE_MAX         = 16'hFFFF;

   localparam logic [1:0] ACT_READ  = 2'd0;
   localparam logic [1:0] ACT_WRITE = 2'd1;
   localparam logic [1:0] ACT_TICK  = 2'd2;
   localparam logic [1:0] ACT_FLUSH = 2'd3;

   localparam logic [1:0] PATH_NONE  = 2'd0;
   localparam logic [1:0] PATH_CACHE = 2'd1;
   localparam logic [1:0] PATH_STORE = 2'd2;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] block;
      logic        store_fails;
   } req_type;

   typedef struct packed {
      logic        status;
      logic [1:0]  data_path;
      logic [5:0]  slot;
      logic [31:0] store_block;
      logic        seek;
      logic        flush;
      logic [31:0] flush_first;
      logic [6:0]  flush_count;
   } rsp_type;

   typedef struct packed {
      logic [31:0] disk_blocks;
      logic [31:0] base_block;
      logic [15:0] idle_limit;
      logic        cache_enabled;
   } cfg_type;

endpackage
`default_nettype wire

@@ src/sqrc_csr.sv @@
// Configuration registers of the run write cache.
// Depends on sqrc_pkg for register indexes and the cfg_type struct.
`default_nettype none
module sqrc_csr
   import sqrc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                     cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.disk_blocks   <= '0;
         cfg_ff.base_block    <= '0;
         cfg_ff.idle_limit    <= IDLE_LIMIT_RESET;
         cfg_ff.cache_enabled <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DISK_BLOCKS:   cfg_ff.disk_blocks   <= csr_wdata;
            CSR_BASE_BLOCK:    cfg_ff.base_block    <= csr_wdata;
            CSR_IDLE_LIMIT:    cfg_ff.idle_limit    <= csr_wdata[15:0];
            CSR_CACHE_ENABLED: cfg_ff.cache_enabled <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

@@ src/sqrc_engine.sv @@
// Run state registers and the per-request decision logic.
// Depends on sqrc_pkg; driven by the input register of the top level.
`default_nettype none
module sqrc_engine
   import sqrc_pkg::*;
#(
   parameter int CACHE_BLOCKS = CACHE_BLOCKS_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    item_valid,
   input  wire req_type item,
   input  wire cfg_type cfg,
   output rsp_type      rsp
);

   localparam int CNT_W = $clog2(CACHE_BLOCKS + 1);

   logic [31:0]      run_first_ff, run_first_in;
   logic [CNT_W-1:0] run_count_ff, run_count_in;
   logic             sticky_ff, sticky_in;
   logic [15:0]      idle_ff, idle_in;
   logic [31:0]      last_block_ff, last_block_in;
   logic             last_valid_ff, last_valid_in;

   logic [31:0] cnt_ext;
   logic [31:0] off;
   logic [31:0] last_next;
   logic [15:0] idle_inc;
   logic        has_run, above_first, in_run, append, in_range, fails;
   logic        flush_now, store_now, store_seek;

   assign cnt_ext     = 32'(run_count_ff);
   assign off         = item.block - run_first_ff;
   assign last_next   = last_block_ff + 32'd1;
   assign idle_inc    = (idle_ff == IDLE_MAX) ? idle_ff : idle_ff + 16'd1;
   assign has_run     = run_count_ff != '0;
   assign above_first = item.block >= run_first_ff;
   assign in_run      = has_run && above_first && (off < cnt_ext);
   assign append      = above_first && (off == cnt_ext)
                        && (run_count_ff < CNT_W'(CACHE_BLOCKS));
   assign in_range    = item.block < cfg.disk_blocks;
   assign fails       = item.store_fails;

   always_comb begin
      rsp           = '0;
      run_first_in  = run_first_ff;
      run_count_in  = run_count_ff;
      sticky_in     = sticky_ff;
      idle_in       = idle_ff;
      last_block_in = last_block_ff;
      last_valid_in = last_valid_ff;
      flush_now     = 1'b0;
      store_now     = 1'b0;
      store_seek    = 1'b0;

      case (item.action)
         ACT_READ: begin
            if (!in_range) begin
               rsp.status    = 1'b1;
               last_valid_in = 1'b0;
            end else if (in_run) begin
               rsp.data_path = PATH_CACHE;
               rsp.slot      = off[5:0];
            end else begin
               store_now  = 1'b1;
               store_seek = (item.block == '0) || !last_valid_ff
                            || (item.block != last_next);
            end
         end
         ACT_WRITE: begin
            if (!in_range) begin
               rsp.status    = 1'b1;
               last_valid_in = 1'b0;
            end else if (sticky_ff) begin
               rsp.status = 1'b1;
            end else if (!cfg.cache_enabled) begin
               flush_now = has_run;
               if (has_run && fails) begin
                  rsp.status = 1'b1;
               end else begin
                  store_now  = 1'b1;
                  store_seek = has_run || !last_valid_ff || (item.block != last_next);
               end
            end else if (in_run) begin
               rsp.data_path = PATH_CACHE;
               rsp.slot      = off[5:0];
               idle_in       = '0;
            end else if (!has_run || append) begin
               if (!has_run) begin
                  run_first_in = item.block;
               end
               rsp.data_path = PATH_CACHE;
               rsp.slot      = cnt_ext[5:0];
               run_count_in  = run_count_ff + CNT_W'(1);
               idle_in       = '0;
            end else begin
               flush_now = 1'b1;
               if (fails) begin
                  rsp.status = 1'b1;
               end else begin
                  rsp.data_path = PATH_CACHE;
                  rsp.slot      = '0;
               end
            end
         end
         ACT_TICK: begin
            idle_in = idle_inc;
            if (has_run && (idle_inc >= cfg.idle_limit)) begin
               flush_now  = 1'b1;
               rsp.status = fails;
            end
         end
         ACT_FLUSH: begin
            if (has_run) begin
               flush_now  = 1'b1;
               rsp.status = fails;
            end
         end
         default: ;
      endcase

      // flush empties the run, then a refill after a clean flush starts a new one
      if (flush_now) begin
         rsp.flush       = 1'b1;
         rsp.flush_first = run_first_ff;
         rsp.flush_count = cnt_ext[6:0];
         rsp.seek        = 1'b1;
         run_count_in    = '0;
         sticky_in       = fails;
         last_valid_in   = 1'b0;
         if (item.action == ACT_WRITE && cfg.cache_enabled && !fails) begin
            run_first_in = item.block;
            run_count_in = CNT_W'(1);
            idle_in      = '0;
         end
      end

      if (store_now) begin
         rsp.data_path = PATH_STORE;
         rsp.store_block = cfg.base_block + item.block;
         rsp.seek        = rsp.seek | store_seek;
         rsp.status      = fails;
         last_block_in   = item.block;
         last_valid_in   = !fails;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_first_ff  <= '0;
         run_count_ff  <= '0;
         sticky_ff     <= 1'b0;
         idle_ff       <= '0;
         last_block_ff <= '0;
         last_valid_ff <= 1'b0;
      end else if (item_valid) begin
         run_first_ff  <= run_first_in;
         run_count_ff  <= run_count_in;
         sticky_ff     <= sticky_in;
         idle_ff       <= idle_in;
         last_block_ff <= last_block_in;
         last_valid_ff <= last_valid_in;
      end
   end

endmodule
`default_nettype wire

@@ src/sequential_run_write_cache_core.sv @@
// Top level of the sequential run write cache: request and result registers.
// Depends on sqrc_pkg, sqrc_csr and sqrc_engine.
//
// One request is taken every clock cycle, as the whole decision is one short
// combinational pass between the request and result registers; busy is tied
// low, so start may be held high continuously. A request accepted at one edge
// is registered, decided against the run state in the next cycle, and its
// result is registered and shown with rsp_valid for a single cycle. The
// run state updates at the same edge that captures the result, so
// back-to-back requests see each other's effects in order. Results cannot be
// held off and must be taken in the cycle they are shown.
`default_nettype none
module sequential_run_write_cache_core
   import sqrc_pkg::*;
#(
   parameter int CACHE_BLOCKS = CACHE_BLOCKS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire req_type                req_item,
   output logic                        rsp_valid,
   output rsp_type                     rsp_item,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type cfg;
   req_type req_ff;
   logic    req_valid_ff;
   rsp_type rsp_in, rsp_ff;
   logic    rsp_valid_ff;

   assign busy = 1'b0;

   sqrc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sqrc_engine #(
      .CACHE_BLOCKS (CACHE_BLOCKS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .item_valid (req_valid_ff),
      .item       (req_ff),
      .cfg        (cfg),
      .rsp        (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_item;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule
`default_nettype wire
